>>> design/hkvt_pkg.sv
// hkvt_pkg: shared types and codes for the hashed key-value table
// no dependencies
package hkvt_pkg;

    typedef enum logic [2:0] {
        MODE_FIND  = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_DEL   = 3'd2,
        MODE_POP   = 3'd3,
        MODE_START = 3'd4,
        MODE_NEXT  = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_DONE      = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_SHIFT,
        S_SCAN,
        S_RDOUT,
        S_OUT
    } t_state;

endpackage

>>> design/hashed_key_value_table.sv
// hashed_key_value_table: bounded bucketed key-value store with one shared key
// compare and a one-read, one-write key/value memory driven by a small sequencer
// depends on hkvt_pkg
//
// find, add and delete search the bucket slot by slot and stop early on a hit;
// a found delete then shifts the later entries down; pop and iteration next
// scan the buckets, one bucket count per cycle; iteration start and unused
// modes go straight to the result
// one item at a time: ready again in the same cycle the result enters the output register
// reset: synchronous active low, clears bucket valid bits and walk state;
// key/value memory and count memory are not cleared, no clearing pass
module hashed_key_value_table
    import hkvt_pkg::*;
#(
    parameter int BUCKET_COUNT    = 64,
    parameter int WAYS_PER_BUCKET = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_key,
    input  logic [63:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [63:0] o_key_out,
    output logic [63:0] o_value_out
);

    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int WW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int FW = $clog2(WAYS_PER_BUCKET + 1);
    localparam int AW = $clog2(BUCKET_COUNT * WAYS_PER_BUCKET);
    localparam int WBW = $clog2(BUCKET_COUNT + 1);
    localparam int DEPTH = BUCKET_COUNT * WAYS_PER_BUCKET;
    localparam logic [FW-1:0] WAYS = FW'(WAYS_PER_BUCKET);
    localparam logic [BW-1:0] MASK = BW'(BUCKET_COUNT - 1);

    // storage
    logic [63:0]   r_kmem [DEPTH];
    logic [63:0]   r_vmem [DEPTH];
    logic [FW-1:0] r_fmem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] r_fvld;

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [63:0]   r_key, n_key, r_val, n_val;
    logic [BW-1:0] r_bkt, n_bkt;
    logic [FW-1:0] r_slot, n_slot;
    logic          r_hit, n_hit;
    logic [WW-1:0] r_hslot, n_hslot;
    logic [WBW-1:0] r_wbkt, n_wbkt;
    logic [FW-1:0] r_wslot, n_wslot;
    logic          r_wact, n_wact;
    logic [2:0]    r_st, n_st;
    logic [63:0]   r_ko, n_ko, r_vo, n_vo;
    logic          r_ovld, n_ovld;
    logic [2:0]    r_ost;
    logic [63:0]   r_oko, r_ovo;

    // memory port controls
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [63:0]   mem_wk, mem_wv;
    logic [63:0]   r_rk, r_rv;
    logic          fill_we;
    logic [BW-1:0] fill_wa;
    logic [FW-1:0] fill_wd;
    logic [BW-1:0] fill_ra;
    logic [FW-1:0] r_frd;
    logic          r_fok;

    logic [FW-1:0] cur_fill;
    logic [BW-1:0] wb_m1;

    function automatic logic [AW-1:0] addr(input logic [BW-1:0] b, input logic [FW-1:0] s);
        addr = AW'(b) * AW'(WAYS_PER_BUCKET) + AW'(s);
    endfunction

    // count of the bucket in r_bkt, read with n_bkt as address so it lines up with r_bkt
    assign fill_ra  = n_bkt;
    assign cur_fill = r_fok ? r_frd : '0;
    assign wb_m1    = BW'(r_wbkt - WBW'(1));

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_ovld;
    assign o_status    = r_ost;
    assign o_key_out   = r_oko;
    assign o_value_out = r_ovo;

    // state register and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wbkt  <= '0;
            r_wslot <= '0;
            r_wact  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wbkt  <= n_wbkt;
            r_wslot <= n_wslot;
            r_wact  <= n_wact;
            r_ovld  <= n_ovld;
        end
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_val   <= n_val;
        r_bkt   <= n_bkt;
        r_slot  <= n_slot;
        r_hit   <= n_hit;
        r_hslot <= n_hslot;
        r_st    <= n_st;
        r_ko    <= n_ko;
        r_vo    <= n_vo;
    end

    // result beat register, loaded when the sequencer hands over a result
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovld || !i_stall)) begin
            r_ost <= r_st;
            r_oko <= r_ko;
            r_ovo <= r_vo;
        end
    end

    // key/value memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_kmem[mem_wa] <= mem_wk;
            r_vmem[mem_wa] <= mem_wv;
        end
        r_rk <= r_kmem[mem_ra];
        r_rv <= r_vmem[mem_ra];
    end

    // bucket count memory, registered read
    always_ff @(posedge i_clk) begin
        if (fill_we) r_fmem[fill_wa] <= fill_wd;
        r_frd <= r_fmem[fill_ra];
    end

    // per bucket valid bits, a bucket reads as empty until first written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvld <= '0;
            r_fok  <= 1'b0;
        end else begin
            if (fill_we) r_fvld[fill_wa] <= 1'b1;
            r_fok <= r_fvld[fill_ra];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;  n_mode = r_mode;  n_key = r_key;  n_val = r_val;
        n_bkt = r_bkt;  n_slot = r_slot;  n_hit = r_hit;  n_hslot = r_hslot;
        n_wbkt = r_wbkt;  n_wslot = r_wslot;  n_wact = r_wact;
        n_st = r_st;  n_ko = r_ko;  n_vo = r_vo;  n_ovld = r_ovld;
        mem_we = 1'b0;  mem_wa = addr(r_bkt, r_slot);  mem_ra = addr(r_bkt, r_slot);
        mem_wk = r_key;  mem_wv = r_val;
        fill_we = 1'b0;  fill_wa = r_bkt;  fill_wd = cur_fill;

        if (r_ovld && !i_stall) n_ovld = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = i_key;
                    n_val  = i_value;
                    n_bkt  = i_key[BW-1:0] & MASK;
                    n_slot = '0;
                    n_hit  = 1'b0;
                    n_st   = ST_OK;
                    n_ko   = '0;
                    n_vo   = '0;
                    case (i_mode)
                        MODE_FIND, MODE_ADD, MODE_DEL: n_state = S_SEARCH;
                        MODE_POP: begin
                            n_bkt   = '0;
                            n_state = S_SCAN;
                        end
                        MODE_START: begin
                            n_wbkt  = '0;
                            n_wslot = '0;
                            n_wact  = 1'b0;
                            n_state = S_OUT;
                        end
                        MODE_NEXT: begin
                            n_bkt   = r_wact ? wb_m1 : r_wbkt[BW-1:0];
                            n_state = S_SCAN;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            // one slot read per cycle, compared in the cycle after
            S_SEARCH: begin
                if (r_slot != '0 && r_rk == r_key && !r_hit) begin
                    n_hit   = 1'b1;
                    n_hslot = WW'(r_slot - FW'(1));
                end
                if (r_slot >= cur_fill || (r_slot != '0 && r_rk == r_key) || r_hit) begin
                    n_state = S_DECIDE;
                    mem_ra  = addr(r_bkt, FW'(n_hslot));
                end else begin
                    n_slot = r_slot + FW'(1);
                end
            end
            S_DECIDE: begin
                n_state = S_OUT;
                case (r_mode)
                    MODE_FIND: begin
                        if (r_hit) n_vo = r_rv;
                        else       n_st = ST_NOT_FOUND;
                    end
                    MODE_ADD: begin
                        if (r_hit) n_st = ST_DUPLICATE;
                        else if (cur_fill >= WAYS) n_st = ST_FULL;
                        else begin
                            mem_we  = 1'b1;
                            mem_wa  = addr(r_bkt, cur_fill);
                            fill_we = 1'b1;
                            fill_wd = cur_fill + FW'(1);
                        end
                    end
                    default: begin
                        if (!r_hit) n_st = ST_NOT_FOUND;
                        else begin
                            n_slot  = FW'(r_hslot) + FW'(1);
                            mem_ra  = addr(r_bkt, FW'(r_hslot) + FW'(1));
                            n_state = S_SHIFT;
                        end
                    end
                endcase
            end
            // move entries above the deleted one down by one
            S_SHIFT: begin
                if (r_slot >= cur_fill) begin
                    fill_we = 1'b1;
                    fill_wd = cur_fill - FW'(1);
                    n_state = S_OUT;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = addr(r_bkt, r_slot - FW'(1));
                    mem_wk = r_rk;
                    mem_wv = r_rv;
                    n_slot = r_slot + FW'(1);
                    mem_ra = addr(r_bkt, r_slot + FW'(1));
                end
            end
            // one bucket count tested per cycle
            S_SCAN: begin
                if (r_mode == MODE_POP) begin
                    if (cur_fill != '0) begin
                        n_slot  = cur_fill - FW'(1);
                        mem_ra  = addr(r_bkt, cur_fill - FW'(1));
                        fill_we = 1'b1;
                        fill_wd = cur_fill - FW'(1);
                        n_state = S_RDOUT;
                    end else if (r_bkt == MASK || 32'(r_bkt) == BUCKET_COUNT - 1) begin
                        n_st    = ST_EMPTY;
                        n_state = S_OUT;
                    end else begin
                        n_bkt = r_bkt + BW'(1);
                    end
                end else if (r_wact && (r_wbkt == '0 || r_wbkt > WBW'(BUCKET_COUNT)
                                        || r_wslot >= cur_fill)) begin
                    n_wact = 1'b0;
                    n_bkt  = r_wbkt[BW-1:0];
                end else if (r_wact) begin
                    n_bkt   = wb_m1;
                    mem_ra  = addr(wb_m1, cur_fill - FW'(1) - r_wslot);
                    n_wslot = r_wslot + FW'(1);
                    if (r_wslot + FW'(1) >= cur_fill) n_wact = 1'b0;
                    n_state = S_RDOUT;
                end else if (r_wbkt >= WBW'(BUCKET_COUNT)) begin
                    n_wbkt  = WBW'(BUCKET_COUNT);
                    n_st    = ST_DONE;
                    n_state = S_OUT;
                end else if (cur_fill == '0) begin
                    n_wbkt = r_wbkt + WBW'(1);
                    n_bkt  = BW'(r_wbkt + WBW'(1));
                end else begin
                    n_wbkt  = r_wbkt + WBW'(1);
                    n_wslot = '0;
                    n_wact  = 1'b1;
                    n_bkt   = r_wbkt[BW-1:0];
                end
            end
            S_RDOUT: begin
                n_state = S_OUT;
                n_ko    = r_rk;
                n_vo    = r_rv;
            end
            S_OUT: begin
                if (!r_ovld || !i_stall) begin
                    n_ovld  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // result beat must not be overwritten while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_key_out) && $stable(o_status))
        else $error("result dropped under stall");
    // no input beat taken while busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> o_stall)
        else $error("ready while busy");
    // bucket count never above the way count
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_we |-> fill_wd <= WAYS)
        else $error("bucket overfilled");
    // walk bucket stays in range
    a_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wbkt <= WBW'(BUCKET_COUNT))
        else $error("walk bucket out of range");

endmodule
